// ===== design/ttft_pkg.sv =====
// Shared types and constants for the tap tempo frequency tracker.
// No dependencies; imported by every design module.
package ttft_pkg;

    localparam int FREQ_W  = 16;  // frequency word, unsigned fixed point
    localparam int COUNT_W = 16;  // tick counter and interval registers
    localparam int KNOB_W  = 12;  // raw knob reading
    localparam int SUM_W   = 19;  // 3*old + 2*new + 2 fits here
    localparam int PROD_W  = 2 * SUM_W;
    localparam int IN_W    = 32;  // input tdata, padded to bytes
    localparam int OUT_W   = 24;  // output tdata, padded to bytes
    localparam int ADDR_W  = 2;

    // Blend (3*old + 2*new + 2) / 5 as a multiply by ceil(2^21 / 5) and a shift;
    // exact for every sum below 2^21 / 3
    localparam int                AVG_SHIFT = 21;
    localparam logic [SUM_W-1:0]  AVG_RECIP = 19'd419431;

    // Register indexes
    localparam logic [ADDR_W-1:0] REG_TICKS_PER_SEC = 2'd0;
    localparam logic [ADDR_W-1:0] REG_TIMEOUT       = 2'd1;
    localparam logic [ADDR_W-1:0] REG_MIN_INTERVAL  = 2'd2;
    localparam logic [ADDR_W-1:0] REG_KNOB_THRESH   = 2'd3;

    typedef struct packed {
        logic [COUNT_W-1:0] ticks_per_second;
        logic [COUNT_W-1:0] timeout_count;
        logic [COUNT_W-1:0] min_interval;
        logic [KNOB_W-1:0]  knob_threshold;
    } ttft_cfg_t;

    // Divider status back to the sequencer
    typedef struct packed {
        logic done;       // one-cycle pulse, quotient valid
        logic saturated;  // quotient exceeded 16 bits
    } div_stat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_TAP,
        ST_BLEND,
        ST_FINISH
    } ttft_state_t;

endpackage

// ===== design/ttft_div.sv =====
// Restoring divider, one quotient bit per cycle, 16-bit quotient with a saturation flag.
// Depends on ttft_pkg.
module ttft_div
    import ttft_pkg::*;
#(
    parameter int NUM_W = 27
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NUM_W-1:0]    num,
    input  logic [COUNT_W-1:0]  den,
    output div_stat_t           stat,
    output logic [FREQ_W-1:0]   quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [NUM_W-1:0]   num_reg, num_next;
    logic [COUNT_W-1:0] den_reg, den_next;
    logic [COUNT_W-1:0] rem_reg, rem_next;
    logic [FREQ_W-1:0]  quot_reg, quot_next;
    logic               sat_reg, sat_next;

    logic [COUNT_W:0]   rem_sh;
    logic               ge;
    logic [COUNT_W:0]   rem_sub;

    // One restoring step: shift in next numerator bit, trial subtract
    assign rem_sh  = {rem_reg, num_reg[NUM_W-1]};
    assign ge      = rem_sh >= {1'b0, den_reg};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        sat_next  = sat_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
            quot_next = '0;
            sat_next  = 1'b0;
        end
        else if (busy_reg)
        begin
            num_next  = {num_reg[NUM_W-2:0], 1'b0};
            rem_next  = ge ? rem_sub[COUNT_W-1:0] : rem_sh[COUNT_W-1:0];
            // a one pushed out of the top means quotient > 0xFFFF
            sat_next  = sat_reg | quot_reg[FREQ_W-1];
            quot_next = {quot_reg[FREQ_W-2:0], ge};
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        sat_reg  <= sat_next;
    end

    assign stat.done      = done_reg;
    assign stat.saturated = sat_reg;
    assign quot           = quot_reg;

endmodule

// ===== design/ttft_ctrl.sv =====
// Tick sequencer and tracker state: tap timing, blend, knob override, result register.
// Depends on ttft_pkg; drives the divider ttft_div.
module ttft_ctrl
    import ttft_pkg::*;
#(
    parameter int FREQ_FRAC_BITS = 10,
    parameter int NUM_W = 27
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  ttft_cfg_t           cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                tap_edge,
    input  logic [KNOB_W-1:0]   knob_position,
    input  logic [FREQ_W-1:0]   knob_frequency,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [FREQ_W-1:0]   lfo_frequency,
    output logic                tapping_active,
    output logic                tap_mode,
    output logic                tap_accepted,
    output logic                div_start,
    output logic [NUM_W-1:0]    div_num,
    output logic [COUNT_W-1:0]  div_den,
    input  div_stat_t           div_stat,
    input  logic [FREQ_W-1:0]   div_quot
);

    ttft_state_t        state_reg, state_next;

    logic [COUNT_W-1:0] count_reg, count_next;
    logic               armed_reg, armed_next;
    logic               avg_reg, avg_next;
    logic               override_reg, override_next;
    logic [FREQ_W-1:0]  tap_freq_reg, tap_freq_next;
    logic [KNOB_W-1:0]  last_knob_reg, last_knob_next;
    logic [FREQ_W-1:0]  cur_freq_reg, cur_freq_next;
    logic               take_reg, take_next;
    logic [KNOB_W-1:0]  knob_reg, knob_next;
    logic [FREQ_W-1:0]  kfreq_reg, kfreq_next;
    logic [SUM_W-1:0]   blend_reg, blend_next;

    logic               out_valid_reg, out_valid_next;
    logic [FREQ_W-1:0]  out_freq_reg, out_freq_next;
    logic               out_armed_reg, out_armed_next;
    logic               out_mode_reg, out_mode_next;
    logic               out_acc_reg, out_acc_next;

    logic               accept;
    logic               out_free;
    logic [COUNT_W-1:0] cnt_inc;
    logic               take;
    logic               timed_out;
    logic [FREQ_W-1:0]  fresh;
    logic [SUM_W-1:0]   blend_sum;
    logic [PROD_W-1:0]  blend_prod;
    logic [FREQ_W-1:0]  blend_quot;
    logic [KNOB_W-1:0]  knob_diff;
    logic               moved;

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Tap decision on the incremented count
    assign cnt_inc   = count_reg + COUNT_W'(1);
    assign take      = armed_reg && tap_edge && (cnt_inc > cfg.min_interval);
    assign timed_out = cnt_inc >= cfg.timeout_count;

    assign fresh     = div_stat.saturated ? {FREQ_W{1'b1}} : div_quot;
    assign blend_sum = SUM_W'({tap_freq_reg, 1'b0}) + SUM_W'(tap_freq_reg)
                     + SUM_W'({fresh, 2'b00}) - SUM_W'({fresh, 1'b0}) + SUM_W'(2);

    // Divide the registered blend sum by 5
    assign blend_prod = PROD_W'(blend_reg) * PROD_W'(AVG_RECIP);
    assign blend_quot = blend_prod[AVG_SHIFT +: FREQ_W];

    // Knob movement against the stored position
    assign knob_diff = (knob_reg >= last_knob_reg) ? (knob_reg - last_knob_reg)
                                                   : (last_knob_reg - knob_reg);
    assign moved     = knob_diff > cfg.knob_threshold;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = take ? ST_DIV_TAP : ST_FINISH;
            end
            ST_DIV_TAP:
            begin
                if (div_stat.done)
                    state_next = avg_reg ? ST_BLEND : ST_FINISH;
            end
            ST_BLEND:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: handshake and divider operands
    always_comb
    begin
        in_ready  = 1'b0;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                div_start = accept && take;
                div_num   = (NUM_W'(cfg.ticks_per_second) << FREQ_FRAC_BITS)
                          + NUM_W'(cnt_inc[COUNT_W-1:1]);
                div_den   = cnt_inc;
            end
            ST_DIV_TAP, ST_BLEND, ST_FINISH:
            begin
                in_ready = 1'b0;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Tracker state and result register
    always_comb
    begin
        count_next     = count_reg;
        armed_next     = armed_reg;
        avg_next       = avg_reg;
        override_next  = override_reg;
        tap_freq_next  = tap_freq_reg;
        last_knob_next = last_knob_reg;
        cur_freq_next  = cur_freq_reg;
        take_next      = take_reg;
        knob_next      = knob_reg;
        kfreq_next     = kfreq_reg;
        blend_next     = blend_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_freq_next  = out_freq_reg;
        out_armed_next = out_armed_reg;
        out_mode_next  = out_mode_reg;
        out_acc_next   = out_acc_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    knob_next  = knob_position;
                    kfreq_next = knob_frequency;
                    take_next  = take;
                    if (armed_reg)
                    begin
                        if (take)
                            count_next = '0;
                        else if (timed_out)
                        begin
                            count_next = '0;
                            armed_next = 1'b0;
                            avg_next   = 1'b0;
                        end
                        else
                            count_next = cnt_inc;
                    end
                    else if (tap_edge)
                        armed_next = 1'b1;
                end
            end
            ST_DIV_TAP:
            begin
                if (div_stat.done)
                begin
                    if (avg_reg)
                        blend_next = blend_sum;
                    else
                    begin
                        // first interval after arming: no blend
                        tap_freq_next = fresh;
                        cur_freq_next = fresh;
                        avg_next      = 1'b1;
                        override_next = 1'b1;
                    end
                end
            end
            ST_BLEND:
            begin
                tap_freq_next = blend_quot;
                cur_freq_next = blend_quot;
                override_next = 1'b1;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    if (!override_reg)
                    begin
                        cur_freq_next  = kfreq_reg;
                        last_knob_next = knob_reg;
                    end
                    else if (moved)
                        override_next = 1'b0;
                    out_valid_next = 1'b1;
                    out_freq_next  = override_reg ? cur_freq_reg : kfreq_reg;
                    out_armed_next = armed_reg;
                    out_mode_next  = override_reg && !moved;
                    out_acc_next   = take_reg;
                end
            end
            default:
            begin
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            armed_reg     <= 1'b0;
            avg_reg       <= 1'b0;
            override_reg  <= 1'b0;
            tap_freq_reg  <= '0;
            last_knob_reg <= '0;
            cur_freq_reg  <= FREQ_W'(1 << FREQ_FRAC_BITS);
            take_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            armed_reg     <= armed_next;
            avg_reg       <= avg_next;
            override_reg  <= override_next;
            tap_freq_reg  <= tap_freq_next;
            last_knob_reg <= last_knob_next;
            cur_freq_reg  <= cur_freq_next;
            take_reg      <= take_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        knob_reg      <= knob_next;
        kfreq_reg     <= kfreq_next;
        blend_reg     <= blend_next;
        out_freq_reg  <= out_freq_next;
        out_armed_reg <= out_armed_next;
        out_mode_reg  <= out_mode_next;
        out_acc_reg   <= out_acc_next;
    end

    assign out_valid      = out_valid_reg;
    assign lfo_frequency  = out_freq_reg;
    assign tapping_active = out_armed_reg;
    assign tap_mode       = out_mode_reg;
    assign tap_accepted   = out_acc_reg;

endmodule

// ===== design/tap_tempo_frequency_tracker.sv =====
// Tap tempo frequency tracker: top level, register file and stream packing.
// Depends on ttft_pkg, ttft_ctrl and ttft_div.
//
// One input beat is one control tick; each tick yields exactly one output beat.
// A tick without an accepted tap goes straight from idle to the finish step,
// which registers the output beat and returns to idle for the next input beat.
// A tick that accepts a tap runs the bit-serial divider: the first interval
// after arming takes the divider quotient as it is, and each later tap adds
// a step to register the 3/5 old + 2/5 new blend sum, which is then divided
// by 5 with a reciprocal multiply.
// The input is not ready while a tick is in progress; a finished result waits
// in the output register and does not hold off the next input beat, but that
// next tick holds in its last step until the output register is free.
// Frequencies are unsigned 16-bit fixed point with FREQ_FRAC_BITS fraction bits.
module tap_tempo_frequency_tracker
    import ttft_pkg::*;
#(
    parameter int FREQ_FRAC_BITS = 10
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // [0] tap_edge, [12:1] knob_position, [28:13] knob_frequency, [31:29] zero
    input  logic [IN_W-1:0]     s_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // [15:0] lfo_frequency, [16] tapping_active, [17] tap_mode,
    // [18] tap_accepted, [23:19] zero
    output logic [OUT_W-1:0]    m_axis_tdata,
    input  logic                cfg_we,
    input  logic [ADDR_W-1:0]   cfg_addr,
    input  logic [COUNT_W-1:0]  cfg_wdata
);

    localparam int NUM_W = COUNT_W + FREQ_FRAC_BITS + 1;

    ttft_cfg_t          cfg_reg, cfg_next;

    logic [FREQ_W-1:0]  lfo_frequency;
    logic               tapping_active;
    logic               tap_mode;
    logic               tap_accepted;
    logic               div_start;
    logic [NUM_W-1:0]   div_num;
    logic [COUNT_W-1:0] div_den;
    div_stat_t          div_stat;
    logic [FREQ_W-1:0]  div_quot;

    // Register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                REG_TICKS_PER_SEC: cfg_next.ticks_per_second = cfg_wdata;
                REG_TIMEOUT:       cfg_next.timeout_count    = cfg_wdata;
                REG_MIN_INTERVAL:  cfg_next.min_interval     = cfg_wdata;
                REG_KNOB_THRESH:   cfg_next.knob_threshold   = cfg_wdata[KNOB_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ticks_per_second <= 16'd12000;
            cfg_reg.timeout_count    <= 16'd36036;
            cfg_reg.min_interval     <= 16'd343;
            cfg_reg.knob_threshold   <= 12'd205;
        end
        else
            cfg_reg <= cfg_next;
    end

    ttft_ctrl #(
        .FREQ_FRAC_BITS (FREQ_FRAC_BITS),
        .NUM_W          (NUM_W)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .tap_edge       (s_axis_tdata[0]),
        .knob_position  (s_axis_tdata[12:1]),
        .knob_frequency (s_axis_tdata[28:13]),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .lfo_frequency  (lfo_frequency),
        .tapping_active (tapping_active),
        .tap_mode       (tap_mode),
        .tap_accepted   (tap_accepted),
        .div_start      (div_start),
        .div_num        (div_num),
        .div_den        (div_den),
        .div_stat       (div_stat),
        .div_quot       (div_quot)
    );

    ttft_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .stat  (div_stat),
        .quot  (div_quot)
    );

    // Output beat packing
    assign m_axis_tdata = {5'd0, tap_accepted, tap_mode, tapping_active, lfo_frequency};

endmodule

// ===== design/ttft_checker.sv =====
// Port-level checks for the tap tempo frequency tracker, bound to the top level.
// Depends on ttft_pkg.
module ttft_checker
    import ttft_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    input  logic                s_axis_tready,
    input  logic [IN_W-1:0]     s_axis_tdata,
    input  logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  logic [OUT_W-1:0]    m_axis_tdata,
    input  logic                cfg_we
);

    // A stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat dropped or changed while stalled");

    // A waiting input beat holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
        else $error("input beat dropped or changed while waiting");

    // One tick at a time: busy right after taking a beat
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while a tick was in progress");

    // An accepted tap keeps the tracker armed
    a_accept_armed: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[18] |-> m_axis_tdata[16])
        else $error("tap accepted while not armed");

    // Register writes must land only while the block is empty; the block itself does not enforce this
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |-> s_axis_tready && !m_axis_tvalid)
        else $error("register written while a tick was in flight");

endmodule

bind tap_tempo_frequency_tracker ttft_checker u_ttft_checker (.*);
